// ===== rtl/ilh_pkg.sv =====
// ----------------------------------------------------------------------------
// Interval log2 histogram package
// Shared widths, constants, item kinds and stage types.
// ----------------------------------------------------------------------------
package ilh_pkg;

    localparam int PID_W        = 23;
    localparam int TS_W         = 64;
    localparam int BIN_W        = 5;
    localparam int CNT_W        = 32;
    localparam int NUM_BINS_DEF = 26;

    localparam logic [TS_W-1:0] US_DIV = TS_W'(1000);
    localparam logic [TS_W-1:0] MS_DIV = TS_W'(1000000);

    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_RECORD = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    typedef struct packed {
        logic [1:0]       kind;
        logic [TS_W-1:0]  delta;
        logic [BIN_W-1:0] idx;
    } s1_item_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [BIN_W-1:0] bin;
        logic             in_range;
    } bin_item_t;

endpackage

// ===== rtl/ilh_cfg.sv =====
// ----------------------------------------------------------------------------
// Interval log2 histogram configuration registers
// APB write and read access to the process filter and the time unit.
// ----------------------------------------------------------------------------
module ilh_cfg
    import ilh_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output logic [PID_W-1:0] target_pid,
    output logic             unit_ms
);

    localparam logic REG_TARGET_PID = 1'b0;
    localparam logic REG_UNIT_MS    = 1'b1;

    logic [PID_W-1:0] target_pid_reg;
    logic             unit_ms_reg;
    logic             wr_en;
    logic             reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_pid_reg <= '0;
            unit_ms_reg    <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_TARGET_PID: target_pid_reg <= pwdata[PID_W-1:0];
                REG_UNIT_MS:    unit_ms_reg    <= pwdata[0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_TARGET_PID: prdata = 32'(target_pid_reg);
            REG_UNIT_MS:    prdata = 32'(unit_ms_reg);
            default:        prdata = '0;
        endcase
    end

    assign target_pid = target_pid_reg;
    assign unit_ms    = unit_ms_reg;

endmodule

// ===== rtl/ilh_front.sv =====
// ----------------------------------------------------------------------------
// Interval log2 histogram input stage
// Filters events, tracks the last timestamp and registers the interval.
// ----------------------------------------------------------------------------
module ilh_front
    import ilh_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             mode,
    input  logic [PID_W-1:0] process_id,
    input  logic [TS_W-1:0]  timestamp_ns,
    input  logic [BIN_W-1:0] bin_index,
    input  logic [PID_W-1:0] target_pid,
    input  logic             s1_take,
    output logic             s1_valid,
    output s1_item_t         s1_item
);

    logic            s1_valid_reg;
    s1_item_t        s1_item_reg;
    s1_item_t        s1_item_next;
    logic [TS_W-1:0] last_time_reg;
    logic            have_last_reg;
    logic            accept;
    logic            pass;

    assign in_stall = s1_valid_reg && !s1_take;
    assign accept   = in_valid && !in_stall;
    assign pass     = !mode && ((target_pid == '0) || (process_id == target_pid));

    always_comb
    begin
        s1_item_next.delta = timestamp_ns - last_time_reg;
        s1_item_next.idx   = bin_index;
        if (mode)
            s1_item_next.kind = KIND_READ;
        else if (pass && have_last_reg)
            s1_item_next.kind = KIND_RECORD;
        else
            s1_item_next.kind = KIND_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            have_last_reg <= 1'b0;
            last_time_reg <= '0;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_take)
                s1_valid_reg <= 1'b0;
            if (accept && pass)
            begin
                have_last_reg <= 1'b1;
                last_time_reg <= timestamp_ns;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_item_reg <= s1_item_next;
    end

    assign s1_valid = s1_valid_reg;
    assign s1_item  = s1_item_reg;

endmodule

// ===== rtl/ilh_bin.sv =====
// ----------------------------------------------------------------------------
// Interval log2 histogram bin selection
// Maps the interval to a clamped log2 bin by comparing against scaled powers
// of two, and picks the bin address for reads.
// ----------------------------------------------------------------------------
module ilh_bin
    import ilh_pkg::*;
#(
    parameter int NUM_BINS = NUM_BINS_DEF,
    parameter int AW       = $clog2(NUM_BINS)
)
(
    input  s1_item_t      s1_item,
    input  logic          unit_ms,
    output bin_item_t     bin_item,
    output logic [AW-1:0] bin_addr
);

    logic [TS_W-1:0] divisor;
    logic [AW-1:0]   slot;

    assign divisor = unit_ms ? MS_DIV : US_DIV;

    // The quotient reaches 2^j exactly when the interval shifted by j
    // reaches the divisor, so the highest such j is the floor log2.
    always_comb
    begin
        slot = '0;
        for (int j = 1; j < NUM_BINS; j++)
        begin
            if ((s1_item.delta >> j) >= divisor)
                slot = AW'(j);
        end
    end

    always_comb
    begin
        bin_item.kind = s1_item.kind;
        case (s1_item.kind)
            KIND_RECORD:
            begin
                bin_item.bin      = BIN_W'(slot);
                bin_item.in_range = 1'b1;
                bin_addr          = slot;
            end
            KIND_READ:
            begin
                bin_item.bin      = s1_item.idx;
                bin_item.in_range = (int'(s1_item.idx) < NUM_BINS);
                bin_addr          = AW'(s1_item.idx);
            end
            default:
            begin
                bin_item.bin      = '0;
                bin_item.in_range = 1'b0;
                bin_addr          = '0;
            end
        endcase
    end

endmodule

// ===== rtl/ilh_hist.sv =====
// ----------------------------------------------------------------------------
// Interval log2 histogram counter store
// Holds the bin counts, performs the read-modify-write with forwarding and
// drives the result register.
// ----------------------------------------------------------------------------
module ilh_hist
    import ilh_pkg::*;
#(
    parameter int NUM_BINS = NUM_BINS_DEF,
    parameter int AW       = $clog2(NUM_BINS)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s1_valid,
    output logic             s1_take,
    input  bin_item_t        bin_item,
    input  logic [AW-1:0]    bin_addr,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             recorded,
    output logic [BIN_W-1:0] bin,
    output logic [CNT_W-1:0] bin_count
);

    logic [CNT_W-1:0] mem [NUM_BINS];
    logic [NUM_BINS-1:0] bin_vld_reg;

    logic             s2_valid_reg;
    bin_item_t        s2_item_reg;
    logic [AW-1:0]    s2_addr_reg;
    logic [CNT_W-1:0] rd_data_reg;
    logic             rd_vld_reg;
    logic             fwd_hit_reg;
    logic [CNT_W-1:0] fwd_data_reg;

    logic             out_valid_reg;
    logic             recorded_reg;
    logic [BIN_W-1:0] bin_reg;
    logic [CNT_W-1:0] count_reg;

    logic             out_en;
    logic             s2_en;
    logic             wr_en;
    logic [CNT_W-1:0] cur;
    logic [CNT_W-1:0] wr_data;
    logic [CNT_W-1:0] count_next;

    assign out_en  = !out_valid_reg || !out_stall;
    assign s2_en   = !s2_valid_reg || out_en;
    assign s1_take = s1_valid && s2_en;
    assign wr_en   = s2_valid_reg && out_en && (s2_item_reg.kind == KIND_RECORD);

    assign cur     = fwd_hit_reg ? fwd_data_reg : (rd_vld_reg ? rd_data_reg : '0);
    assign wr_data = cur + CNT_W'(1);

    always_comb
    begin
        case (s2_item_reg.kind)
            KIND_RECORD: count_next = wr_data;
            KIND_READ:   count_next = s2_item_reg.in_range ? cur : '0;
            default:     count_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[s2_addr_reg] <= wr_data;
        if (s2_en)
            rd_data_reg <= mem[bin_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_vld_reg   <= '0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            rd_vld_reg    <= 1'b0;
        end
        else
        begin
            if (wr_en)
                bin_vld_reg[s2_addr_reg] <= 1'b1;
            if (s2_en)
            begin
                s2_valid_reg <= s1_valid;
                rd_vld_reg   <= bin_vld_reg[bin_addr];
                fwd_hit_reg  <= wr_en && (s2_addr_reg == bin_addr);
            end
            if (out_en)
                out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_en)
        begin
            s2_item_reg  <= bin_item;
            s2_addr_reg  <= bin_addr;
            fwd_data_reg <= wr_data;
        end
        if (out_en && s2_valid_reg)
        begin
            recorded_reg <= (s2_item_reg.kind == KIND_RECORD);
            bin_reg      <= s2_item_reg.bin;
            count_reg    <= count_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign recorded  = recorded_reg;
    assign bin       = bin_reg;
    assign bin_count = count_reg;

endmodule

// ===== rtl/entry_interval_log2_histogram_unit.sv =====
// ----------------------------------------------------------------------------
// Entry interval log2 histogram unit
// Builds a log2 histogram of the intervals between function entry events and
// returns bin counts on request.
//
//   Channel   Direction   Handshake              Payload
//   in        input       in_valid / in_stall    mode, process_id,
//                                                timestamp_ns, bin_index
//   out       output      out_valid / out_stall  recorded, bin, bin_count
//   cfg       APB slave   psel / penable         paddr, pwdata, prdata
//
// One item is accepted per cycle while in_stall is low; each result is
// loaded into the output register after passing through the input, bin
// and result registers, and a stall can hold it between them.
// Reset clears the histogram at once through per-bin valid flags.
// A stalled result holds the output register, and the stall ripples back
// through the stages only as far as there are no empty slots.
// ----------------------------------------------------------------------------
module entry_interval_log2_histogram_unit
    import ilh_pkg::*;
#(
    parameter int NUM_BINS = NUM_BINS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             mode,
    input  logic [PID_W-1:0] process_id,
    input  logic [TS_W-1:0]  timestamp_ns,
    input  logic [BIN_W-1:0] bin_index,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             recorded,
    output logic [BIN_W-1:0] bin,
    output logic [CNT_W-1:0] bin_count
);

    localparam int AW = $clog2(NUM_BINS);

    logic [PID_W-1:0] target_pid;
    logic             unit_ms;
    logic             s1_valid;
    logic             s1_take;
    s1_item_t         s1_item;
    bin_item_t        bin_item;
    logic [AW-1:0]    bin_addr;

    ilh_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .target_pid (target_pid),
        .unit_ms    (unit_ms)
    );

    ilh_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .process_id   (process_id),
        .timestamp_ns (timestamp_ns),
        .bin_index    (bin_index),
        .target_pid   (target_pid),
        .s1_take      (s1_take),
        .s1_valid     (s1_valid),
        .s1_item      (s1_item)
    );

    ilh_bin #(
        .NUM_BINS (NUM_BINS),
        .AW       (AW)
    ) u_bin (
        .s1_item  (s1_item),
        .unit_ms  (unit_ms),
        .bin_item (bin_item),
        .bin_addr (bin_addr)
    );

    ilh_hist #(
        .NUM_BINS (NUM_BINS),
        .AW       (AW)
    ) u_hist (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1_valid  (s1_valid),
        .s1_take   (s1_take),
        .bin_item  (bin_item),
        .bin_addr  (bin_addr),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .recorded  (recorded),
        .bin       (bin),
        .bin_count (bin_count)
    );

endmodule
